FILE: hw/rtl/cmf_pkg.sv
// ----------------------------------------------------------------------------
// cmf_pkg
// shared types and constants of the checksummed message framer
// ----------------------------------------------------------------------------
package cmf_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned REM_W  = 9;

    localparam logic [BYTE_W-1:0] FRAME_HEAD  = 8'hFF;
    localparam logic [BYTE_W-1:0] FRAME_TAIL  = 8'hEF;
    localparam logic [BYTE_W:0]   SUM_MODULUS = 9'd255;

    typedef struct packed {
        logic              start_of_frame;
        logic [BYTE_W-1:0] sender_ident;
        logic [BYTE_W-1:0] receiver_ident;
        logic [BYTE_W-1:0] length_field;
        logic [BYTE_W-1:0] payload_byte;
    } t_in_word;

    typedef struct packed {
        logic              fire;
        logic [BYTE_W-1:0] frame_byte;
        logic              frame_last;
    } t_emit;

endpackage

FILE: hw/rtl/cmf_in_if.sv
// ----------------------------------------------------------------------------
// cmf_in_if
// payload byte channel with frame header fields
// ----------------------------------------------------------------------------
interface cmf_in_if;
    logic       valid;
    logic       ready;
    logic       start_of_frame;
    logic [7:0] sender_ident;
    logic [7:0] receiver_ident;
    logic [7:0] length_field;
    logic [7:0] payload_byte;

    modport source (
        output valid, start_of_frame, sender_ident, receiver_ident,
               length_field, payload_byte,
        input  ready
    );
    modport sink (
        input  valid, start_of_frame, sender_ident, receiver_ident,
               length_field, payload_byte,
        output ready
    );
endinterface

FILE: hw/rtl/cmf_out_if.sv
// ----------------------------------------------------------------------------
// cmf_out_if
// framed byte channel
// ----------------------------------------------------------------------------
interface cmf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_last;

    modport source (
        output valid, frame_byte, frame_last,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, frame_last,
        output ready
    );
endinterface

FILE: hw/rtl/cmf_in_stage.sv
// ----------------------------------------------------------------------------
// cmf_in_stage
// input register, holds one word until the sequencer has finished it
// ----------------------------------------------------------------------------
module cmf_in_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    cmf_in_if.sink           i_in,
    input  logic             i_done,
    output logic             o_valid,
    output cmf_pkg::t_in_word o_word
);

    logic              r_valid;
    cmf_pkg::t_in_word r_word;
    logic              accept;

    assign i_in.ready = !r_valid || i_done;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_done) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_word.start_of_frame <= i_in.start_of_frame;
            r_word.sender_ident   <= i_in.sender_ident;
            r_word.receiver_ident <= i_in.receiver_ident;
            r_word.length_field   <= i_in.length_field;
            r_word.payload_byte   <= i_in.payload_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_word;

endmodule

FILE: hw/rtl/cmf_seq.sv
// ----------------------------------------------------------------------------
// cmf_seq
// frame sequencer: picks the next frame byte, keeps the running checksum,
// the remaining payload count and the open-frame flag
// ----------------------------------------------------------------------------
module cmf_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  cmf_pkg::t_in_word i_word,
    input  logic              i_out_load,
    output cmf_pkg::t_emit    o_emit,
    output logic              o_done
);

    typedef enum logic [2:0] {
        P_START,
        P_HEAD,
        P_SND,
        P_RCV,
        P_LEN,
        P_PAY,
        P_SUM,
        P_TAIL
    } t_phase;

    t_phase                             r_phase, n_phase, cur;
    logic                               r_open, n_open;
    logic [cmf_pkg::REM_W-1:0]          r_rem, n_rem;
    logic [cmf_pkg::BYTE_W-1:0]         r_sum, n_sum;
    logic                               active, fire, last_pay;
    logic [cmf_pkg::BYTE_W-1:0]         sel_byte, sum_in;
    logic [cmf_pkg::BYTE_W:0]           sum_raw;
    logic [cmf_pkg::BYTE_W-1:0]         sum_mod;

    assign cur      = (r_phase == P_START)
                    ? (i_word.start_of_frame ? P_HEAD : P_PAY) : r_phase;
    assign active   = i_valid && (i_word.start_of_frame || r_open);
    assign fire     = active && i_out_load;
    assign last_pay = (r_rem == cmf_pkg::REM_W'(1));

    always_comb begin
        unique case (cur)
            P_HEAD:  sel_byte = cmf_pkg::FRAME_HEAD;
            P_SND:   sel_byte = i_word.sender_ident;
            P_RCV:   sel_byte = i_word.receiver_ident;
            P_LEN:   sel_byte = i_word.length_field;
            P_PAY:   sel_byte = i_word.payload_byte;
            P_SUM:   sel_byte = r_sum;
            P_TAIL:  sel_byte = cmf_pkg::FRAME_TAIL;
            default: sel_byte = i_word.payload_byte;
        endcase
    end

    // modulo 255 add, both operands stay below 2 * 255
    assign sum_in  = (cur == P_HEAD) ? '0 : r_sum;
    assign sum_raw = {1'b0, sum_in} + {1'b0, sel_byte};
    assign sum_mod = (sum_raw >= cmf_pkg::SUM_MODULUS)
                   ? cmf_pkg::BYTE_W'(sum_raw - cmf_pkg::SUM_MODULUS)
                   : cmf_pkg::BYTE_W'(sum_raw);

    always_comb begin
        n_phase = r_phase;
        n_open  = r_open;
        n_rem   = r_rem;
        n_sum   = r_sum;
        o_done  = i_valid && !active;
        if (fire) begin
            unique case (cur)
                P_HEAD: begin
                    n_sum   = sum_mod;
                    n_phase = P_SND;
                end
                P_SND: begin
                    n_sum   = sum_mod;
                    n_phase = P_RCV;
                end
                P_RCV: begin
                    n_sum   = sum_mod;
                    n_phase = P_LEN;
                end
                P_LEN: begin
                    n_sum   = sum_mod;
                    n_open  = 1'b1;
                    n_rem   = {1'b0, i_word.length_field} + cmf_pkg::REM_W'(1);
                    n_phase = P_PAY;
                end
                P_PAY: begin
                    n_sum   = sum_mod;
                    n_rem   = r_rem - cmf_pkg::REM_W'(1);
                    n_phase = last_pay ? P_SUM : P_START;
                    o_done  = !last_pay;
                end
                P_SUM: begin
                    n_phase = P_TAIL;
                end
                P_TAIL: begin
                    n_sum   = '0;
                    n_open  = 1'b0;
                    n_phase = P_START;
                    o_done  = 1'b1;
                end
                default: begin
                    n_phase = P_START;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= P_START;
            r_open  <= 1'b0;
            r_rem   <= '0;
            r_sum   <= '0;
        end else begin
            r_phase <= n_phase;
            r_open  <= n_open;
            r_rem   <= n_rem;
            r_sum   <= n_sum;
        end
    end

    assign o_emit.fire       = fire;
    assign o_emit.frame_byte = sel_byte;
    assign o_emit.frame_last = (cur == P_TAIL);

endmodule

FILE: hw/rtl/cmf_out_stage.sv
// ----------------------------------------------------------------------------
// cmf_out_stage
// output register of the framed byte channel
// ----------------------------------------------------------------------------
module cmf_out_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  cmf_pkg::t_emit i_emit,
    output logic           o_load,
    cmf_out_if.source      o_out
);

    logic                       r_valid;
    logic [cmf_pkg::BYTE_W-1:0] r_byte;
    logic                       r_last;

    assign o_load = !r_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_load) begin
            r_valid <= i_emit.fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_emit.fire) begin
            r_byte <= i_emit.frame_byte;
            r_last <= i_emit.frame_last;
        end
    end

    assign o_out.valid      = r_valid;
    assign o_out.frame_byte = r_byte;
    assign o_out.frame_last = r_last;

endmodule

FILE: hw/rtl/checksummed_message_framer_core.sv
// ----------------------------------------------------------------------------
// checksummed_message_framer_core
// builds checksummed byte frames from a stream of payload words
// ----------------------------------------------------------------------------
// Each accepted word is held in an input register while the sequencer moves
// its frame bytes, one per cycle unless the output stalls, into the output
// register. A continuing payload word emits only its payload byte, so payload
// streams at one word per cycle when not stalled; a word that opens a frame
// emits 0xFF, sender, receiver, length and payload, and the word that closes
// a frame adds the checksum and the trailer 0xEF. A word with no frame open
// is dropped without emitting a byte. Back-pressure on the output stalls the
// sequencer and, through it, the input.
// ----------------------------------------------------------------------------
module checksummed_message_framer_core (
    input  logic      i_clk,
    input  logic      i_rst_n,
    cmf_in_if.sink    i_in,
    cmf_out_if.source o_out
);

    logic              in_valid;
    cmf_pkg::t_in_word in_word;
    logic              done;
    logic              out_load;
    cmf_pkg::t_emit    emit;

    cmf_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_done  (done),
        .o_valid (in_valid),
        .o_word  (in_word)
    );

    cmf_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_valid),
        .i_word     (in_word),
        .i_out_load (out_load),
        .o_emit     (emit),
        .o_done     (done)
    );

    cmf_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_emit  (emit),
        .o_load  (out_load),
        .o_out   (o_out)
    );

endmodule

FILE: hw/rtl/cmf_checker.sv
// ----------------------------------------------------------------------------
// cmf_checker
// port-level checks of the framer, bound to the top level
// ----------------------------------------------------------------------------
module cmf_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_in_sof,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_byte,
    input logic       i_out_last
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte)
                                        && $stable(i_out_last))
        else $error("output word changed while stalled");

    // only the trailer ends a frame
    a_last_tail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_last |-> i_out_byte == cmf_pkg::FRAME_TAIL)
        else $error("frame end on a byte other than the trailer");

    // a frame start keeps the input busy with its header
    a_sof_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_sof |=> !i_in_ready)
        else $error("input ready right after a frame start");

    // no two trailers back to back
    a_no_double_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_out_last |=> !(i_out_valid && i_out_last))
        else $error("two frame ends in a row");

endmodule

bind checksummed_message_framer_core cmf_checker u_cmf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_sof    (i_in.start_of_frame),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_byte  (o_out.frame_byte),
    .i_out_last  (o_out.frame_last)
);

FILE: dv/checksummed_message_framer_core_test.sv
// ----------------------------------------------------------------------------
// checksummed_message_framer_core_test
// self-checking bench for the checksummed message framer
// ----------------------------------------------------------------------------
// Payload words are driven on the input channel, and every accepted word is
// run through a local framing predictor that queues the frame bytes it should
// produce. Each accepted output byte is checked against the oldest queued
// byte. Directed words cover orphan words, single-word frames, a short frame,
// abandoned frames and the longest frame. Random traffic then runs under
// three idle profiles: mostly well-formed frames, with some abandoned frames
// and orphan words mixed in.
// ----------------------------------------------------------------------------
module checksummed_message_framer_core_test;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned DRAIN_CYCLES = 16;

    typedef struct packed {
        logic [cmf_pkg::BYTE_W-1:0] frame_byte;
        logic                       frame_last;
    } t_frame_out;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    cmf_in_if  in_if ();
    cmf_out_if out_if ();

    checksummed_message_framer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // predictor state
    logic                       model_open;
    logic [cmf_pkg::REM_W-1:0]  model_left;
    logic [cmf_pkg::BYTE_W-1:0] model_sum;

    t_frame_out  expected_bytes[$];
    t_frame_out  oldest_byte;
    int unsigned framed_words;
    int unsigned fail_count;
    int unsigned cycle_count;
    int unsigned src_idle_pct;
    int unsigned sink_idle_pct;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    function automatic void queue_byte(input logic [cmf_pkg::BYTE_W-1:0] b,
                                       input logic l);
        t_frame_out o;
        o.frame_byte = b;
        o.frame_last = l;
        expected_bytes.push_back(o);
    endfunction

    function automatic void queue_summed(input logic [cmf_pkg::BYTE_W-1:0] b);
        logic [cmf_pkg::BYTE_W:0] acc;
        acc = {1'b0, model_sum} + {1'b0, b};
        if (acc >= cmf_pkg::SUM_MODULUS) begin
            acc = acc - cmf_pkg::SUM_MODULUS;
        end
        model_sum = acc[cmf_pkg::BYTE_W-1:0];
        queue_byte(b, 1'b0);
    endfunction

    function automatic void predict_frame(input cmf_pkg::t_in_word w);
        if (w.start_of_frame) begin
            model_sum = '0;
            queue_summed(cmf_pkg::FRAME_HEAD);
            queue_summed(w.sender_ident);
            queue_summed(w.receiver_ident);
            queue_summed(w.length_field);
            model_open = 1'b1;
            model_left = {1'b0, w.length_field} + 1'b1;
        end else if (!model_open) begin
            return;
        end
        queue_summed(w.payload_byte);
        model_left = model_left - 1'b1;
        if (model_left == '0) begin
            queue_byte(model_sum, 1'b0);
            queue_byte(cmf_pkg::FRAME_TAIL, 1'b1);
            model_open = 1'b0;
            model_sum = '0;
        end
        framed_words++;
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && out_if.valid && out_if.ready) begin
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected frame word, expected none, actual %h last %b",
                         $time, out_if.frame_byte, out_if.frame_last);
                fail_count++;
            end else begin
                oldest_byte = expected_bytes.pop_front();
                if (out_if.frame_byte !== oldest_byte.frame_byte) begin
                    $display("%0t: frame_byte mismatch, expected %h, actual %h",
                             $time, oldest_byte.frame_byte, out_if.frame_byte);
                    fail_count++;
                end
                if (out_if.frame_last !== oldest_byte.frame_last) begin
                    $display("%0t: frame_last mismatch, expected %b, actual %b",
                             $time, oldest_byte.frame_last, out_if.frame_last);
                    fail_count++;
                end
            end
        end
    end

    function automatic cmf_pkg::t_in_word make_word(input logic sof, input logic [7:0] snd,
                                                    input logic [7:0] rcv,
                                                    input logic [7:0] len,
                                                    input logic [7:0] pay);
        cmf_pkg::t_in_word w;
        w.start_of_frame = sof;
        w.sender_ident   = snd;
        w.receiver_ident = rcv;
        w.length_field   = len;
        w.payload_byte   = pay;
        return w;
    endfunction

    function automatic cmf_pkg::t_in_word rand_word(input logic sof, input logic [7:0] len);
        return make_word(sof, 8'($urandom_range(255)), 8'($urandom_range(255)), len,
                         8'($urandom_range(255)));
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input cmf_pkg::t_in_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid = 1'b0;
            @(negedge i_clk);
        end
        in_if.valid          = 1'b1;
        in_if.start_of_frame = w.start_of_frame;
        in_if.sender_ident   = w.sender_ident;
        in_if.receiver_ident = w.receiver_ident;
        in_if.length_field   = w.length_field;
        in_if.payload_byte   = w.payload_byte;
        do begin
            @(posedge i_clk);
        end while (!in_if.ready);
        predict_frame(w);
        @(negedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] len);
        send_word(rand_word(1'b1, len));
        repeat (len) send_word(rand_word(1'b0, 8'($urandom_range(255))));
    endtask

    task automatic test_orphan_words;
        send_word(make_word(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_word(make_word(1'b0, 8'h00, 8'h00, 8'h00, 8'hFF));
    endtask

    task automatic test_single_word_frames;
        send_word(make_word(1'b1, 8'h00, 8'h00, 8'h00, 8'h00));
        send_word(make_word(1'b1, 8'hFF, 8'hFF, 8'h00, 8'hFF));
        send_word(make_word(1'b1, 8'hA5, 8'h5A, 8'h00, 8'hEF));
    endtask

    task automatic test_short_frame;
        // header fields on continuing words must be ignored
        send_word(make_word(1'b1, 8'h12, 8'h34, 8'h03, 8'h56));
        send_word(make_word(1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00));
        send_word(make_word(1'b0, 8'h00, 8'h00, 8'hFF, 8'hFF));
        send_word(make_word(1'b0, 8'hAA, 8'h55, 8'h80, 8'h7F));
    endtask

    task automatic test_abandoned_frame;
        send_word(make_word(1'b1, 8'h01, 8'h02, 8'hC8, 8'h10));
        send_word(make_word(1'b0, 8'h00, 8'h00, 8'h00, 8'h20));
        send_word(make_word(1'b1, 8'h03, 8'h04, 8'h01, 8'h30));
        send_word(make_word(1'b0, 8'h00, 8'h00, 8'h00, 8'h40));
        send_word(make_word(1'b0, 8'h77, 8'h88, 8'h99, 8'h50));
    endtask

    task automatic test_longest_frame;
        send_frame(8'hFF);
    endtask

    task automatic test_random_traffic(input int unsigned src_pct, input int unsigned sink_pct,
                                       input int unsigned n_words);
        int unsigned first;
        int unsigned r;
        int unsigned len;
        int unsigned k;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        first = framed_words;
        while (framed_words - first < n_words) begin
            r = $urandom_range(99);
            if (r < 75) begin
                k = $urandom_range(99);
                if (k < 70) begin
                    len = $urandom_range(4);
                end else if (k < 95) begin
                    len = $urandom_range(20, 5);
                end else begin
                    len = $urandom_range(60, 21);
                end
                send_frame(8'(len));
            end else if (r < 88) begin
                // open a frame, cut it short with a new one
                len = $urandom_range(255, 1);
                k = $urandom_range((len < 4) ? len - 1 : 3);
                send_word(rand_word(1'b1, 8'(len)));
                repeat (k) send_word(rand_word(1'b0, 8'($urandom_range(255))));
                send_frame(8'h00);
            end else begin
                repeat ($urandom_range(3, 1)) begin
                    send_word(rand_word(1'b0, 8'($urandom_range(255))));
                end
            end
        end
    endtask

    initial begin
        model_open   = 1'b0;
        model_left   = '0;
        model_sum    = '0;
        framed_words = 0;
        src_idle_pct  = 8;
        sink_idle_pct = 76;
        in_if.valid          = 1'b0;
        in_if.start_of_frame = 1'b0;
        in_if.sender_ident   = '0;
        in_if.receiver_ident = '0;
        in_if.length_field   = '0;
        in_if.payload_byte   = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_orphan_words();
        test_single_word_frames();
        test_short_frame();
        test_abandoned_frame();
        test_longest_frame();
        test_random_traffic(8, 76, 75);
        test_random_traffic(76, 8, 75);
        test_random_traffic(0, 0, 75);

        in_if.valid = 1'b0;
        while (expected_bytes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: sim.f
hw/rtl/cmf_pkg.sv
hw/rtl/cmf_in_if.sv
hw/rtl/cmf_out_if.sv
hw/rtl/cmf_in_stage.sv
hw/rtl/cmf_seq.sv
hw/rtl/cmf_out_stage.sv
hw/rtl/checksummed_message_framer_core.sv
hw/rtl/cmf_checker.sv
dv/checksummed_message_framer_core_test.sv
